### hw/rtl/fdss_pkg.sv
// shared types, constants and segment table for the seven-segment scanner
`timescale 1ns / 1ps

package fdss_pkg;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned ShownW    = 14;   // 0..9999
  localparam int unsigned PosW      = 3;
  localparam int unsigned SegW      = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned ProdW     = 30;

  localparam logic signed [ValueW-1:0] MaxShown = 16'sd9999;

  // reciprocal constants, exact for values up to 9999
  localparam logic [ProdW-1:0] RecipTen      = 30'd52429;  // >> 19
  localparam logic [ProdW-1:0] RecipHundred  = 30'd5243;   // >> 19
  localparam logic [ProdW-1:0] RecipThousand = 30'd8389;   // >> 23

  localparam logic [3:0] BlankIdx = 4'd10;

  typedef struct packed {
    logic [ShownW-1:0] value;
    logic [1:0]        pos;
  } s1_t;

  typedef struct packed {
    logic [ShownW-1:0] value;
    logic [9:0]        q_ten;
    logic [6:0]        q_hundred;
    logic [3:0]        q_thousand;
    logic [1:0]        pos;
  } s2_t;

  function automatic logic [SegW-1:0] seg_pattern(input logic [3:0] idx);
    logic [SegW-1:0] pat;
    unique case (idx)
      4'd0:    pat = 8'h81;
      4'd1:    pat = 8'hE7;
      4'd2:    pat = 8'hA8;
      4'd3:    pat = 8'hA4;
      4'd4:    pat = 8'hC6;
      4'd5:    pat = 8'h94;
      4'd6:    pat = 8'h90;
      4'd7:    pat = 8'hA7;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h84;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/fdss_in_if.sv
// request channel: load or scan-tick items
`timescale 1ns / 1ps

interface fdss_in_if;
  logic                                    valid;
  logic                                    ready;
  fdss_pkg::op_e                           operation;
  logic signed [fdss_pkg::ValueW-1:0]      value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

### hw/rtl/fdss_out_if.sv
// result channel: segment lines and digit enables
`timescale 1ns / 1ps

interface fdss_out_if;
  logic                            valid;
  logic                            ready;
  logic [fdss_pkg::SegW-1:0]       segments;
  logic [fdss_pkg::DigitW-1:0]     digit_select;

  modport source (output valid, output segments, output digit_select, input ready);
  modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

### hw/rtl/four_digit_seven_segment_scanner.sv
// four-digit multiplexed seven-segment scanner, top level
//
//   port    dir  request                     fields
//   req_i   in   load value or scan tick     operation, value
//   res_o   out  one digit of the display    segments, digit_select
//
// one request is taken every cycle while req_i.ready is high; a tick that
// shows a digit goes through the request, quotient and output regs to res_o
// held value and scan position update at the accepting edge, so the next
// request sees them at once; only ticks that show a digit enter the pipe
// reset clears held value, position and all pipe valids
// a stall on res_o backs up through the pipe; req_i.ready drops only once
// all three stages are full
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner (
  input  logic clk_i,
  input  logic rst_ni,
  fdss_in_if.sink    req_i,
  fdss_out_if.source res_o
);
  import fdss_pkg::*;

  // architectural state
  logic signed [ValueW-1:0] held_q, held_d;
  logic [PosW-1:0]          pos_q, pos_d;

  // pipe registers
  logic       s1_valid_q, s2_valid_q, out_valid_q;
  s1_t        s1_q, s1_d;
  s2_t        s2_q, s2_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [DigitW-1:0] sel_q, sel_d;

  logic out_en, s2_en, s1_en;
  logic accept, shows_digit;

  // stall chain: a stage moves when the next one is empty or moving
  assign out_en = !out_valid_q || res_o.ready;
  assign s2_en  = !s2_valid_q  || out_en;
  assign s1_en  = !s1_valid_q  || s2_en;

  assign req_i.ready = s1_en;
  assign accept      = req_i.valid && s1_en;

  // a tick shows a digit only with an in-range value at positions 1..4
  assign shows_digit = (req_i.operation == OP_TICK) &&
                       (held_q >= 16'sd0) && (held_q <= MaxShown) &&
                       (pos_q >= 3'd1) && (pos_q <= 3'd4);

  always_comb begin
    held_d = held_q;
    pos_d  = pos_q;
    if (req_i.operation == OP_LOAD) begin
      held_d = req_i.value;
    end else begin
      // clamp into the shown range for later ticks
      if (held_q < 16'sd0) begin
        held_d = '0;
      end else if (held_q > MaxShown) begin
        held_d = MaxShown;
      end
      // cycle 1..4; anything else restarts at 1
      if ((pos_q >= 3'd1) && (pos_q <= 3'd3)) begin
        pos_d = pos_q + 3'd1;
      end else begin
        pos_d = 3'd1;
      end
    end
  end

  // stage 1 capture: value bits and zero-based position
  always_comb begin
    s1_d.value = held_q[ShownW-1:0];
    s1_d.pos   = 2'(pos_q - 3'd1);
  end

  // stage 2: decimal quotients by reciprocal multiply, in parallel
  logic [ProdW-1:0] prod_ten, prod_hundred, prod_thousand;

  always_comb begin
    prod_ten      = ProdW'(s1_q.value) * RecipTen;
    prod_hundred  = ProdW'(s1_q.value) * RecipHundred;
    prod_thousand = ProdW'(s1_q.value) * RecipThousand;
    s2_d.value      = s1_q.value;
    s2_d.q_ten      = prod_ten[28:19];
    s2_d.q_hundred  = prod_hundred[25:19];
    s2_d.q_thousand = prod_thousand[26:23];
    s2_d.pos        = s1_q.pos;
  end

  // output stage: digit = q_p - 10 * q_(p+1), blank when q_p is zero
  logic [ShownW-1:0] q_hi, q_lo, digit_wide;
  logic [3:0]        seg_idx;

  always_comb begin
    unique case (s2_q.pos)
      2'd0: begin
        q_hi = s2_q.value;
        q_lo = ShownW'(s2_q.q_ten);
      end
      2'd1: begin
        q_hi = ShownW'(s2_q.q_ten);
        q_lo = ShownW'(s2_q.q_hundred);
      end
      2'd2: begin
        q_hi = ShownW'(s2_q.q_hundred);
        q_lo = ShownW'(s2_q.q_thousand);
      end
      default: begin
        q_hi = ShownW'(s2_q.q_thousand);
        q_lo = '0;
      end
    endcase
    digit_wide = q_hi - ((q_lo << 3) + (q_lo << 1));
    seg_idx    = (q_hi == '0) ? BlankIdx : digit_wide[3:0];
    seg_d      = ~seg_pattern(seg_idx);
    sel_d      = 4'hF ^ (4'h1 << s2_q.pos);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        held_q <= held_d;
        pos_q  <= pos_d;
      end
      if (s1_en) begin
        s1_valid_q <= accept && shows_digit;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_q <= s1_d;
    end
    if (s2_en) begin
      s2_q <= s2_d;
    end
    if (out_en) begin
      seg_q <= seg_d;
      sel_q <= sel_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.segments     = seg_q;
  assign res_o.digit_select = sel_q;

endmodule

### sim/fdss_digit_checker.sv
// watches both channels, predicts each displayed digit and compares it
`timescale 1ns / 1ps

module fdss_digit_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdss_in_if         req_i,
  fdss_out_if        res_i,
  output int         errors_o,
  output int         pending_o,
  output int         shown_o
);
  import fdss_pkg::*;

  typedef struct packed {
    logic [SegW-1:0]   segments;
    logic [DigitW-1:0] digit_select;
  } shown_digit_t;

  // active-low glyphs, indexed by decimal digit, blank last
  localparam logic [SegW-1:0] Glyph [0:10] = '{
    8'h81, 8'hE7, 8'hA8, 8'hA4, 8'hC6, 8'h94, 8'h90, 8'hA7, 8'h80, 8'h84, 8'hFF
  };

  logic signed [ValueW-1:0] held_q;
  logic [PosW-1:0]          scan_pos_q;
  shown_digit_t             digit_q [$];
  int                       err_count;
  int                       shown_count;

  // one scan tick: returns 1 when a digit is shown, then clamps and advances
  function automatic logic scan_tick(output shown_digit_t d);
    logic [3:0]  digs [4];
    int unsigned v;
    logic        hit;
    hit = (held_q >= 0) && (held_q <= MaxShown) && (scan_pos_q >= 1) && (scan_pos_q <= 4);
    d   = '0;
    if (hit) begin
      v = held_q;
      digs[3] = 4'(v / 1000);
      digs[2] = 4'((v / 100) % 10);
      digs[1] = 4'((v / 10) % 10);
      digs[0] = 4'(v % 10);
      // leading zero blanking, zero itself shows nothing
      if (digs[3] == 0) begin
        digs[3] = BlankIdx;
        if (digs[2] == 0) begin
          digs[2] = BlankIdx;
          if (digs[1] == 0) begin
            digs[1] = BlankIdx;
            if (digs[0] == 0) digs[0] = BlankIdx;
          end
        end
      end
      d.segments     = ~Glyph[digs[scan_pos_q - 1]];
      d.digit_select = 4'hF ^ (4'b0001 << (scan_pos_q - 1));
    end
    if (held_q < 0) held_q = '0;
    if (held_q > MaxShown) held_q = MaxShown;
    scan_pos_q = (scan_pos_q >= 1 && scan_pos_q <= 3) ? scan_pos_q + 1'b1 : PosW'(1);
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shown_digit_t want;
    shown_digit_t next_digit;
    if (!rst_ni) begin
      held_q      = '0;
      scan_pos_q  = '0;
      digit_q.delete();
      err_count   = 0;
      shown_count = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (digit_q.size() == 0) begin
          $error("unexpected digit: segments %h digit_select %b",
                 res_i.segments, res_i.digit_select);
          err_count++;
        end else begin
          want = digit_q.pop_front();
          shown_count++;
          if (res_i.segments !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, res_i.segments);
            err_count++;
          end
          if (res_i.digit_select !== want.digit_select) begin
            $error("digit_select: expected %b, got %b",
                   want.digit_select, res_i.digit_select);
            err_count++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.operation == OP_LOAD) held_q = req_i.value;
        else if (scan_tick(next_digit)) digit_q.push_back(next_digit);
      end
    end
    errors_o  <= err_count;
    pending_o <= digit_q.size();
    shown_o   <= shown_count;
  end

endmodule

### sim/tb_four_digit_seven_segment_scanner.sv
// testbench top: clock, reset, request stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb_four_digit_seven_segment_scanner;
  import fdss_pkg::*;

  localparam int RandomRequests = 1200;
  localparam int CycleLimit     = 200000;
  localparam int IdlePct        = 18;

  logic clk_i;
  logic rst_ni;
  int   cycles = 0;
  int   errors;
  int   pending;
  int   shown;
  int   loads_sent;
  int   ticks_sent;
  logic quiet;     // no idling on either side while set

  fdss_in_if  req_if ();
  fdss_out_if res_if ();

  four_digit_seven_segment_scanner dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  fdss_digit_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .res_i     (res_if),
    .errors_o  (errors),
    .pending_o (pending),
    .shown_o   (shown)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  // watchdog: a hung pipe or a lost handshake ends here
  initial begin
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // result side stalls at random, except during the quiet stretch
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  // one request, with random idling before it; waits on the clock until ready is seen high, then returns
  task automatic send_request(input op_e op, input logic signed [ValueW-1:0] v);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == OP_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  // stop sending and wait until every predicted digit has come out
  task automatic drain_display();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [ValueW-1:0] v;
    int                       pick;
    op_e                      op;
    req_if.valid     = 1'b0;
    req_if.operation = OP_LOAD;
    req_if.value     = '0;
    quiet            = 1'b0;
    loads_sent       = 0;
    ticks_sent       = 0;
    rst_ni           = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first tick at position zero shows nothing
    send_request(OP_TICK, '0);
    send_request(OP_LOAD, 16'sd1234);
    repeat (4) send_request(OP_TICK, '0);       // all four positions, wrap to one
    send_request(OP_LOAD, 16'sd5678);
    repeat (3) send_request(OP_TICK, '0);
    send_request(OP_LOAD, 16'sd0);              // zero is fully blank
    send_request(OP_TICK, '0);
    send_request(OP_LOAD, -16'sd32768);         // negative: no digit, clamped to zero
    send_request(OP_TICK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_LOAD, 16'sd32767);          // too large: no digit, clamped to 9999
    send_request(OP_TICK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_LOAD, 16'sd10000);
    send_request(OP_TICK, '0);
    send_request(OP_LOAD, 16'sd90);             // leading zeros blank above the tens
    repeat (3) send_request(OP_TICK, '0);

    // random part, ticks dominate so most loads get scanned out
    for (int i = 0; i < RandomRequests; i++) begin
      quiet = (i >= 400) && (i < 650);
      if (i == 800) drain_display();          // hold off until the display pipe is empty
      pick = $urandom_range(99);
      op   = (pick < 25) ? OP_LOAD : OP_TICK;
      pick = $urandom_range(99);
      if (pick < 40)      v = ValueW'($urandom_range(9999));
      else if (pick < 60) v = ValueW'($urandom_range(99));
      else if (pick < 70) v = '0;
      else                v = ValueW'($urandom);
      send_request(op, v);
    end

    drain_display();
    repeat (12) @(posedge clk_i);   // room for any stray digit to show up

    $display("run: %0d loads, %0d scan ticks, %0d digits compared",
             loads_sent, ticks_sent, shown);
    $display("  incl. blanking, out-of-range clamps, position wrap and random stalls");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
